/* rtl/core/mre_pkg.sv */
// Shared types and constants of the mini RISC instruction executor.
// Holds the decoded micro-op and result formats used by front, queue and back.
// No dependencies.
package mre_pkg;

	localparam int DATA_WORDS = 256;
	// The load index wraps by masking, so DATA_WORDS is kept a power of two.
	localparam int DMEM_AW = $clog2(DATA_WORDS);
	localparam int NUM_REGS = 8;
	localparam int RF_AW = $clog2(NUM_REGS);
	localparam int QUEUE_DEPTH = 2;
	localparam int QPTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int QCNT_W = $clog2(QUEUE_DEPTH + 1);

	localparam int S_TDATA_W = 32;
	localparam int M_TDATA_W = 24;

	localparam logic [3:0] OPC_RTYPE = 4'd0;
	localparam logic [3:0] OPC_J = 4'd2;
	localparam logic [3:0] OPC_ADDI = 4'd4;
	localparam logic [3:0] OPC_BEQ = 4'd8;
	localparam logic [3:0] OPC_LW = 4'd11;
	localparam logic [3:0] OPC_SW = 4'd15;

	localparam logic [2:0] FN_ADD = 3'd0;
	localparam logic [2:0] FN_SUB = 3'd2;
	localparam logic [2:0] FN_AND = 3'd4;
	localparam logic [2:0] FN_OR = 3'd5;

	typedef enum logic [3:0] {
		K_ALU,
		K_JUMP,
		K_ADDI,
		K_BEQ,
		K_LOAD,
		K_STORE,
		K_NOP,
		K_HALT,
		K_PRELOAD
	} kind_t;

	typedef enum logic [2:0] {
		ALU_ADD,
		ALU_SUB,
		ALU_AND,
		ALU_OR,
		ALU_ZERO
	} alu_op_t;

	typedef struct packed {
		kind_t kind;
		alu_op_t alu_op;
		logic [RF_AW-1:0] rs;
		logic [RF_AW-1:0] rt;
		logic [RF_AW-1:0] rd;
		logic [5:0] imm;
		logic [7:0] jaddr;
		logic [7:0] ld_addr;
		logic [7:0] ld_value;
	} uop_t;

	typedef struct packed {
		logic [7:0] next_pc;
		logic halted;
		logic overflow_fault;
		logic reg_written;
		logic [RF_AW-1:0] dest_reg;
		logic [7:0] dest_value;
	} res_t;

endpackage

/* rtl/core/mre_front.sv */
// Front end: takes input transactions and classifies them into micro-ops.
// Depends on mre_pkg; feeds mre_queue.
module mre_front import mre_pkg::*; (
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // instr_word[15:0], load_addr[23:16], load_value[31:24]
	input  logic                 s_tuser,  // func
	output logic                 push_valid,
	input  logic                 push_ready,
	output uop_t                 push_uop
);

	logic [15:0] word;
	logic [3:0]  opcode;

	assign word = s_tdata[15:0];
	assign opcode = word[15:12];
	assign s_tready = push_ready;
	assign push_valid = s_tvalid;

	always_comb begin
		push_uop = '0;
		push_uop.rs = word[11:9];
		push_uop.rt = word[8:6];
		push_uop.rd = word[5:3];
		push_uop.imm = word[5:0];
		push_uop.jaddr = word[7:0];
		push_uop.ld_addr = s_tdata[23:16];
		push_uop.ld_value = s_tdata[31:24];
		push_uop.alu_op = ALU_ZERO;
		unique case (word[2:0])
			FN_ADD: push_uop.alu_op = ALU_ADD;
			FN_SUB: push_uop.alu_op = ALU_SUB;
			FN_AND: push_uop.alu_op = ALU_AND;
			FN_OR: push_uop.alu_op = ALU_OR;
			default: push_uop.alu_op = ALU_ZERO;
		endcase
		if (s_tuser) begin
			push_uop.kind = K_PRELOAD;
		end else if (word == 16'h0000) begin
			push_uop.kind = K_HALT;
		end else begin
			unique case (opcode)
				OPC_RTYPE: push_uop.kind = K_ALU;
				OPC_J: push_uop.kind = K_JUMP;
				OPC_ADDI: push_uop.kind = K_ADDI;
				OPC_BEQ: push_uop.kind = K_BEQ;
				OPC_LW: push_uop.kind = K_LOAD;
				OPC_SW: push_uop.kind = K_STORE;
				default: push_uop.kind = K_NOP;
			endcase
		end
	end

endmodule

/* rtl/core/mre_queue.sv */
// Short micro-op queue between the front end and the execution back end.
// Depends on mre_pkg.
module mre_queue import mre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push_valid,
	output logic push_ready,
	input  uop_t push_uop,
	output logic pop_valid,
	input  logic pop_ready,
	output uop_t pop_uop
);

	uop_t              slot_q [QUEUE_DEPTH];
	logic [QPTR_W-1:0] wr_ptr_q;
	logic [QPTR_W-1:0] rd_ptr_q;
	logic [QCNT_W-1:0] count_q;
	logic              do_push;
	logic              do_pop;

	assign push_ready = (count_q != QCNT_W'(QUEUE_DEPTH));
	assign pop_valid = (count_q != '0);
	assign pop_uop = slot_q[rd_ptr_q];
	assign do_push = push_valid && push_ready;
	assign do_pop = pop_valid && pop_ready;

	function automatic logic [QPTR_W-1:0] wrap_inc(input logic [QPTR_W-1:0] p);
		if (p == QPTR_W'(QUEUE_DEPTH - 1))
			return '0;
		return p + 1'b1;
	endfunction

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q <= '0;
		end else begin
			if (do_push)
				wr_ptr_q <= wrap_inc(wr_ptr_q);
			if (do_pop)
				rd_ptr_q <= wrap_inc(rd_ptr_q);
			if (do_push && !do_pop)
				count_q <= count_q + 1'b1;
			else if (do_pop && !do_push)
				count_q <= count_q - 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_push)
			slot_q[wr_ptr_q] <= push_uop;
	end

endmodule

/* rtl/core/mre_back.sv */
// Execution back end: register file, data memory, pc and halt state.
// Stage 1 reads registers, stage 2 holds the result and performs writeback.
// Depends on mre_pkg; fed by mre_queue.
module mre_back import mre_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic q_valid,
	input  uop_t q_uop,
	output logic q_pop,
	output logic m_tvalid,
	input  logic m_tready,
	output res_t res
);

	// Architectural state.
	logic [7:0]            rf_q [NUM_REGS];
	logic [NUM_REGS-1:0]   rf_vld_q;
	logic [7:0]            dmem_q [DATA_WORDS];
	logic [DATA_WORDS-1:0] dmem_vld_q;
	logic [7:0]            pc_q;
	logic                  halt_q;

	// Stage 1: micro-op with registered register-file reads.
	logic       valid_s1;
	uop_t       uop_s1;
	logic [7:0] ra_s1;
	logic [7:0] rb_s1;
	logic       ra_vld_s1;
	logic       rb_vld_s1;
	logic       ra_byp_s1;
	logic       rb_byp_s1;
	logic [7:0] byp_val_s1;

	// Stage 2: result waiting for the output transaction.
	logic       valid_s2;
	logic [7:0] pc_s2;
	logic       halted_s2;
	logic       ovf_s2;
	logic       wr_s2;
	logic       is_load_s2;
	logic [RF_AW-1:0] dst_s2;
	logic [7:0] val_s2;
	logic [7:0] mrd_s2;
	logic       mrv_s2;

	logic       advance;
	logic       s1_load;
	logic [7:0] wb_value;
	logic       rf_we;

	logic [7:0] a_file;
	logic [7:0] b_file;
	logic [7:0] a;
	logic [7:0] b;
	logic [7:0] imm8;
	logic [7:0] opnd_b;
	logic       do_sub;
	logic [8:0] sum9;
	logic       ovf_arith;
	logic       ovf;
	logic [7:0] alu_r;
	logic [8:0] seq9;
	logic [9:0] br10;
	logic [9:0] target10;
	logic       taken;

	logic       nxt_halt;
	logic [7:0] nxt_pc;
	logic       nxt_ovf;
	logic       nxt_wr;
	logic       nxt_load;
	logic [RF_AW-1:0] nxt_dst;
	logic [7:0] nxt_val;

	logic       dmem_we;
	logic [DMEM_AW-1:0] dmem_waddr;
	logic [7:0] dmem_wdata;
	logic [DMEM_AW-1:0] ld_idx;

	assign advance = !valid_s2 || m_tready;
	assign s1_load = !valid_s1 || advance;
	assign q_pop = s1_load;

	assign wb_value = is_load_s2 ? (mrv_s2 ? mrd_s2 : 8'h00) : val_s2;
	assign rf_we = valid_s2 && m_tready && wr_s2;

	// Operands: stage 2 holds the newest value, then the write seen at read time.
	assign a_file = ra_byp_s1 ? byp_val_s1 : (ra_vld_s1 ? ra_s1 : 8'h00);
	assign b_file = rb_byp_s1 ? byp_val_s1 : (rb_vld_s1 ? rb_s1 : 8'h00);
	assign a = (valid_s2 && wr_s2 && dst_s2 == uop_s1.rs) ? wb_value : a_file;
	assign b = (valid_s2 && wr_s2 && dst_s2 == uop_s1.rt) ? wb_value : b_file;

	assign imm8 = {{2{uop_s1.imm[5]}}, uop_s1.imm};
	assign opnd_b = (uop_s1.kind == K_ALU || uop_s1.kind == K_BEQ) ? b : imm8;
	assign do_sub = (uop_s1.kind == K_BEQ) ||
		(uop_s1.kind == K_ALU && uop_s1.alu_op == ALU_SUB);
	assign sum9 = do_sub ? ({a[7], a} - {opnd_b[7], opnd_b}) :
		({a[7], a} + {opnd_b[7], opnd_b});
	assign ovf_arith = sum9[8] ^ sum9[7];
	assign ld_idx = sum9[DMEM_AW-1:0];

	always_comb begin
		case (uop_s1.kind) inside
			K_ALU: ovf = ovf_arith &&
				(uop_s1.alu_op == ALU_ADD || uop_s1.alu_op == ALU_SUB);
			K_ADDI, K_BEQ, K_LOAD, K_STORE: ovf = ovf_arith;
			default: ovf = 1'b0;
		endcase
		unique case (uop_s1.alu_op)
			ALU_ADD, ALU_SUB: alu_r = sum9[7:0];
			ALU_AND: alu_r = a & b;
			ALU_OR: alu_r = a | b;
			default: alu_r = 8'h00;
		endcase
	end

	assign seq9 = {1'b0, pc_q} + 9'd1;
	assign br10 = {2'b00, pc_q} + {{4{uop_s1.imm[5]}}, uop_s1.imm} + 10'd1;
	assign taken = (uop_s1.kind == K_BEQ) && (sum9[7:0] == 8'h00);
	assign target10 = (uop_s1.kind == K_JUMP) ? {2'b00, uop_s1.jaddr} :
		(taken ? br10 : {1'b0, seq9});

	always_comb begin
		nxt_halt = halt_q;
		nxt_pc = pc_q;
		nxt_ovf = 1'b0;
		nxt_wr = 1'b0;
		nxt_load = 1'b0;
		nxt_dst = '0;
		nxt_val = 8'h00;
		dmem_we = 1'b0;
		dmem_waddr = uop_s1.ld_addr[DMEM_AW-1:0];
		dmem_wdata = uop_s1.ld_value;
		if (uop_s1.kind == K_PRELOAD) begin
			dmem_we = ({1'b0, uop_s1.ld_addr} < 9'(DATA_WORDS));
		end else if (uop_s1.kind == K_HALT || halt_q) begin
			nxt_halt = 1'b1;
		end else if (ovf) begin
			nxt_halt = 1'b1;
			nxt_ovf = 1'b1;
		end else begin
			case (uop_s1.kind)
				K_ALU: begin
					nxt_wr = 1'b1;
					nxt_dst = uop_s1.rd;
					nxt_val = alu_r;
				end
				K_ADDI: begin
					nxt_wr = 1'b1;
					nxt_dst = uop_s1.rt;
					nxt_val = sum9[7:0];
				end
				K_LOAD: begin
					nxt_wr = 1'b1;
					nxt_load = 1'b1;
					nxt_dst = uop_s1.rt;
				end
				K_STORE: begin
					// Negative addresses and addresses past the memory are dropped.
					dmem_we = !sum9[7] && ({1'b0, sum9[7:0]} < 9'(DATA_WORDS));
					dmem_waddr = sum9[DMEM_AW-1:0];
					dmem_wdata = b;
				end
				default: ;
			endcase
			if (target10[9:8] != 2'b00)
				nxt_halt = 1'b1;
			else
				nxt_pc = target10[7:0];
		end
		if (!(valid_s1 && advance))
			dmem_we = 1'b0;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			pc_q <= '0;
			halt_q <= 1'b0;
			rf_vld_q <= '0;
			dmem_vld_q <= '0;
		end else begin
			if (s1_load)
				valid_s1 <= q_valid;
			if (advance)
				valid_s2 <= valid_s1;
			if (valid_s1 && advance) begin
				pc_q <= nxt_pc;
				halt_q <= nxt_halt;
			end
			if (rf_we)
				rf_vld_q[dst_s2] <= 1'b1;
			if (dmem_we)
				dmem_vld_q[dmem_waddr] <= 1'b1;
		end
	end

	always_ff @(posedge clk) begin
		if (rf_we)
			rf_q[dst_s2] <= wb_value;
		if (s1_load) begin
			uop_s1 <= q_uop;
			ra_s1 <= rf_q[q_uop.rs];
			rb_s1 <= rf_q[q_uop.rt];
			ra_vld_s1 <= rf_vld_q[q_uop.rs];
			rb_vld_s1 <= rf_vld_q[q_uop.rt];
			ra_byp_s1 <= rf_we && (dst_s2 == q_uop.rs);
			rb_byp_s1 <= rf_we && (dst_s2 == q_uop.rt);
			byp_val_s1 <= wb_value;
		end
	end

	always_ff @(posedge clk) begin
		if (dmem_we)
			dmem_q[dmem_waddr] <= dmem_wdata;
		if (advance) begin
			mrd_s2 <= dmem_q[ld_idx];
			mrv_s2 <= dmem_vld_q[ld_idx];
			pc_s2 <= nxt_pc;
			halted_s2 <= nxt_halt;
			ovf_s2 <= nxt_ovf;
			wr_s2 <= nxt_wr;
			is_load_s2 <= nxt_load;
			dst_s2 <= nxt_dst;
			val_s2 <= nxt_val;
		end
	end

	assign m_tvalid = valid_s2;
	assign res.next_pc = pc_s2;
	assign res.halted = halted_s2;
	assign res.overflow_fault = ovf_s2;
	assign res.reg_written = wr_s2;
	assign res.dest_reg = dst_s2;
	assign res.dest_value = wr_s2 ? wb_value : 8'h00;

`ifndef ASSERT_OFF
	a_ovf_halts: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && ovf_s2 |-> halted_s2 && !wr_s2)
		else $error("overflow result without halt or with a register write");

	a_halt_sticks: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> halt_q)
		else $error("halt flag cleared without reset");

	a_halt_pc_frozen: assert property (@(posedge clk) disable iff (!arst_n)
		halt_q |=> $stable(pc_q))
		else $error("pc moved while halted");

	a_no_store_halted: assert property (@(posedge clk) disable iff (!arst_n)
		dmem_we && (uop_s1.kind != K_PRELOAD) |-> !halt_q)
		else $error("store executed while halted");
`endif

endmodule

/* rtl/core/mini_risc_instruction_executor.sv */
// Top level of the mini RISC instruction executor.
// Instantiates mre_front, mre_queue and mre_back; depends on mre_pkg.
//
// Usage:
// The slave channel takes one transaction per item: tuser is the function
// (execute the instruction word, or preload one data memory byte), tdata
// carries the instruction word, preload address and preload byte.
// The master channel returns exactly one result transaction per item, in
// order: next pc, halted, overflow fault, register-written flag, destination
// register and destination value.
// Throughput is one item per cycle while the receiver does not stall. A
// result passes through the micro-op queue and the register read stage;
// the result register then holds it until it is taken. Register
// forwarding and a registered data memory read keep dependent instructions
// and loads at that rate.
// Reset clears the pc, the halt flag and the valid bits of the register file
// and data memory, so every register and byte reads as zero right away.
// When the receiver stalls, the back end holds its result and stops; the
// two-entry queue fills and then tready on the slave side drops.
module mini_risc_instruction_executor import mre_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [S_TDATA_W-1:0] s_tdata,  // instr_word[15:0], load_addr[23:16], load_value[31:24]
	input  logic                 s_tuser,  // func
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [M_TDATA_W-1:0] m_tdata   // next_pc[7:0], halted[8], overflow_fault[9],
	                                       // reg_written[10], dest_reg[13:11],
	                                       // dest_value[21:14], zero[23:22]
);

	logic push_valid;
	logic push_ready;
	uop_t push_uop;
	logic pop_valid;
	logic pop_ready;
	uop_t pop_uop;
	res_t res;

	mre_front u_front (
		.s_tvalid   (s_tvalid),
		.s_tready   (s_tready),
		.s_tdata    (s_tdata),
		.s_tuser    (s_tuser),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_uop   (push_uop)
	);

	mre_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push_valid (push_valid),
		.push_ready (push_ready),
		.push_uop   (push_uop),
		.pop_valid  (pop_valid),
		.pop_ready  (pop_ready),
		.pop_uop    (pop_uop)
	);

	mre_back u_back (
		.clk      (clk),
		.arst_n   (arst_n),
		.q_valid  (pop_valid),
		.q_uop    (pop_uop),
		.q_pop    (pop_ready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.res      (res)
	);

	assign m_tdata = {2'b00, res.dest_value, res.dest_reg, res.reg_written,
		res.overflow_fault, res.halted, res.next_pc};

endmodule
